FILE: rtl/gbas_pkg.sv
package gbas_pkg;

  // Fixed field widths
  localparam int MODE_W    = 2;
  localparam int COORD_W   = 15;
  localparam int INV_W     = 16;
  localparam int LEVEL_W   = 3;
  localparam int SLEVEL_W  = 4;
  localparam int IDX_OUT_W = 6;
  localparam int CIDX_W    = 8;   // column or row index, grid side up to 256
  localparam int REG_IDX_W = 1;
  localparam int FRAC_SH   = 20;  // Q11.4 times Q0.16 down to whole cells

  // Item modes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_CELL_W_INV = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_CELL_H_INV = 1'b1;
  localparam logic [INV_W-1:0]     INV_RESET      = 16'd6554;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_INSERT,
    OP_QUERY
  } op_t;

  // Classified command from the front part
  typedef struct packed {
    op_t                        op;
    logic [COORD_W-1:0]         pos_x;
    logic [COORD_W-1:0]         pos_y;
    logic [COORD_W-1:0]         radius;
    logic [LEVEL_W-1:0]         level;
    logic signed [SLEVEL_W-1:0] min_level;
    logic signed [SLEVEL_W-1:0] max_level;
    logic                       hit;    // low cell corner lies inside the grid
    logic [CIDX_W-1:0]          col0;
    logic [CIDX_W-1:0]          row0;
    logic [CIDX_W-1:0]          col1;
    logic [CIDX_W-1:0]          row1;
  } cmd_t;

  typedef enum logic [3:0] {
    B_INIT,
    B_IDLE,
    B_CLR_RD,
    B_CLR_WR,
    B_INS_WR,
    B_INS_LINK,
    B_Q_CELL,
    B_Q_HEAD,
    B_Q_FEAT,
    B_Q_END
  } back_state_t;

endpackage

FILE: rtl/gbas_if.sv
interface gbas_req_if;
  logic                                        valid;
  logic                                        ready;
  logic [gbas_pkg::MODE_W-1:0]                 mode;
  logic [gbas_pkg::COORD_W-1:0]                pos_x;
  logic [gbas_pkg::COORD_W-1:0]                pos_y;
  logic [gbas_pkg::COORD_W-1:0]                radius;
  logic [gbas_pkg::LEVEL_W-1:0]                feature_level;
  logic signed [gbas_pkg::SLEVEL_W-1:0]        min_level;
  logic signed [gbas_pkg::SLEVEL_W-1:0]        max_level;

  modport source (output valid, mode, pos_x, pos_y, radius, feature_level, min_level,
                  max_level, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, radius, feature_level, min_level,
                  max_level, output ready);
endinterface

interface gbas_res_if;
  logic                              valid;
  logic                              ready;
  logic [gbas_pkg::IDX_OUT_W-1:0]    feature_index;
  logic                              found;
  logic                              last;

  modport source (output valid, feature_index, found, last, input ready);
  modport sink   (input valid, feature_index, found, last, output ready);
endinterface

FILE: rtl/grid_bucketed_area_search.sv
// Beats pass a one-stage front register and a two-entry queue to the back part.
// Insert: stores the feature and reads its cell, then links it into the cell list;
// outside the grid there is no link, with a full table nothing. Clear: a read and
// a write per occupied cell. Query: reads each covered cell and each listed feature,
// ends with a last beat; bound by the cell memory port. Reset runs a pass marking
// every cell empty, holding queued beats until it ends. Registers reset to 6554.
module grid_bucketed_area_search #(
  parameter int GRID_COLS    = 64,
  parameter int GRID_ROWS    = 48,
  parameter int MAX_FEATURES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [gbas_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [gbas_pkg::INV_W-1:0]      wr_data,
  gbas_req_if.sink                        req,
  gbas_res_if.source                      res
);
  logic           push;
  logic           push_ready;
  gbas_pkg::cmd_t push_cmd;
  logic           pop;
  logic           pop_valid;
  gbas_pkg::cmd_t pop_cmd;

  gbas_front #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_front (
    .clk, .rst, .wr_en, .wr_index, .wr_data, .req,
    .push, .push_cmd, .push_ready
  );

  gbas_queue u_queue (
    .clk, .rst, .push, .push_cmd, .push_ready,
    .pop, .pop_cmd, .pop_valid
  );

  gbas_back #(
    .GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS), .MAX_FEATURES(MAX_FEATURES)
  ) u_back (
    .clk, .rst, .q_valid(pop_valid), .q_cmd(pop_cmd), .q_pop(pop), .res
  );
endmodule

FILE: rtl/gbas_ram.sv
module gbas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: rtl/gbas_queue.sv
module gbas_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gbas_pkg::cmd_t      push_cmd,
  output logic                push_ready,
  input  logic                pop,
  output gbas_pkg::cmd_t      pop_cmd,
  output logic                pop_valid
);
  gbas_pkg::cmd_t slot [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = slot[rptr];

  // Store command beats
  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      slot[wptr] <= push_cmd;
    end
  end

  // Track fill level and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && push_ready) begin
        wptr <= ~wptr;
      end
      if (pop && pop_valid) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push && push_ready) - 2'(pop && pop_valid);
    end
  end
endmodule

FILE: rtl/gbas_front.sv
module gbas_front #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 48
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   wr_en,
  input  logic [gbas_pkg::REG_IDX_W-1:0]         wr_index,
  input  logic [gbas_pkg::INV_W-1:0]             wr_data,
  gbas_req_if.sink                               req,
  output logic                                   push,
  output gbas_pkg::cmd_t                         push_cmd,
  input  logic                                   push_ready
);
  localparam int LO_W = gbas_pkg::COORD_W + gbas_pkg::INV_W;       // 31
  localparam int HI_W = gbas_pkg::COORD_W + gbas_pkg::INV_W + 2;   // 33
  localparam int LC_W = LO_W - gbas_pkg::FRAC_SH;                  // 11
  localparam int HC_W = HI_W - gbas_pkg::FRAC_SH;                  // 13

  logic [gbas_pkg::INV_W-1:0]           w_inv;
  logic [gbas_pkg::INV_W-1:0]           h_inv;
  logic                                 p_valid;
  logic [gbas_pkg::MODE_W-1:0]          p_mode;
  logic [gbas_pkg::COORD_W-1:0]         p_x;
  logic [gbas_pkg::COORD_W-1:0]         p_y;
  logic [gbas_pkg::COORD_W-1:0]         p_r;
  logic [gbas_pkg::LEVEL_W-1:0]         p_lvl;
  logic signed [gbas_pkg::SLEVEL_W-1:0] p_minl;
  logic signed [gbas_pkg::SLEVEL_W-1:0] p_maxl;

  logic                          mode_ok;
  gbas_pkg::op_t                 op;
  logic                          p_take;
  logic [gbas_pkg::COORD_W-1:0]  sub_r;
  logic [gbas_pkg::COORD_W-1:0]  dx_lo;
  logic [gbas_pkg::COORD_W-1:0]  dy_lo;
  logic [LO_W-1:0]               px_lo;
  logic [LO_W-1:0]               py_lo;
  logic [HI_W-1:0]               px_hi;
  logic [HI_W-1:0]               py_hi;
  logic [LC_W-1:0]               cx_lo;
  logic [LC_W-1:0]               cy_lo;
  logic [HC_W-1:0]               cx_hi;
  logic [HC_W-1:0]               cy_hi;
  logic                          hit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      w_inv <= gbas_pkg::INV_RESET;
      h_inv <= gbas_pkg::INV_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        gbas_pkg::REG_CELL_W_INV: w_inv <= wr_data;
        gbas_pkg::REG_CELL_H_INV: h_inv <= wr_data;
        default: ;
      endcase
    end
  end

  // Classify mode
  always_comb begin
    mode_ok = 1'b1;
    op      = gbas_pkg::OP_CLEAR;
    unique case (p_mode)
      gbas_pkg::MODE_CLEAR:  op = gbas_pkg::OP_CLEAR;
      gbas_pkg::MODE_INSERT: op = gbas_pkg::OP_INSERT;
      gbas_pkg::MODE_QUERY:  op = gbas_pkg::OP_QUERY;
      default:               mode_ok = 1'b0;
    endcase
  end

  // Take the held beat on a push, or drop it for an unused mode
  assign p_take    = p_valid && (push_ready || !mode_ok);
  assign req.ready = !p_valid || p_take;
  assign push      = p_valid && mode_ok;

  // Input holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (req.ready) begin
      p_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      p_mode <= req.mode;
      p_x    <= req.pos_x;
      p_y    <= req.pos_y;
      p_r    <= req.radius;
      p_lvl  <= req.feature_level;
      p_minl <= req.min_level;
      p_maxl <= req.max_level;
    end
  end

  // Cell bounds: floor of low corner, ceiling of high corner
  always_comb begin
    sub_r = (op == gbas_pkg::OP_QUERY) ? p_r : '0;
    dx_lo = (p_x < sub_r) ? '0 : p_x - sub_r;
    dy_lo = (p_y < sub_r) ? '0 : p_y - sub_r;
    px_lo = LO_W'(dx_lo) * LO_W'(w_inv);
    py_lo = LO_W'(dy_lo) * LO_W'(h_inv);
    px_hi = (HI_W'(p_x) + HI_W'(p_r)) * HI_W'(w_inv) + HI_W'((1 << gbas_pkg::FRAC_SH) - 1);
    py_hi = (HI_W'(p_y) + HI_W'(p_r)) * HI_W'(h_inv) + HI_W'((1 << gbas_pkg::FRAC_SH) - 1);
    cx_lo = px_lo[LO_W-1:gbas_pkg::FRAC_SH];
    cy_lo = py_lo[LO_W-1:gbas_pkg::FRAC_SH];
    cx_hi = px_hi[HI_W-1:gbas_pkg::FRAC_SH];
    cy_hi = py_hi[HI_W-1:gbas_pkg::FRAC_SH];
    hit   = (cx_lo < LC_W'(GRID_COLS)) && (cy_lo < LC_W'(GRID_ROWS));
  end

  // Command to the back part
  always_comb begin
    push_cmd.op        = op;
    push_cmd.pos_x     = p_x;
    push_cmd.pos_y     = p_y;
    push_cmd.radius    = p_r;
    push_cmd.level     = p_lvl;
    push_cmd.min_level = p_minl;
    push_cmd.max_level = p_maxl;
    push_cmd.hit       = hit;
    push_cmd.col0      = gbas_pkg::CIDX_W'(cx_lo);
    push_cmd.row0      = gbas_pkg::CIDX_W'(cy_lo);
    push_cmd.col1      = (cx_hi > HC_W'(GRID_COLS - 1)) ? gbas_pkg::CIDX_W'(GRID_COLS - 1)
                                                         : gbas_pkg::CIDX_W'(cx_hi);
    push_cmd.row1      = (cy_hi > HC_W'(GRID_ROWS - 1)) ? gbas_pkg::CIDX_W'(GRID_ROWS - 1)
                                                         : gbas_pkg::CIDX_W'(cy_hi);
  end
endmodule

FILE: rtl/gbas_back.sv
module gbas_back #(
  parameter int GRID_COLS    = 64,
  parameter int GRID_ROWS    = 48,
  parameter int MAX_FEATURES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  gbas_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  gbas_res_if.source         res
);
  localparam int NCELLS = GRID_COLS * GRID_ROWS;
  localparam int CAW    = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int IW     = $clog2(MAX_FEATURES);
  localparam int CW     = 1 + 2 * IW;   // empty flag, head, tail
  localparam int FW     = 2 * gbas_pkg::COORD_W + gbas_pkg::LEVEL_W;

  gbas_pkg::back_state_t state;
  gbas_pkg::back_state_t state_next;

  gbas_pkg::cmd_t             cur;
  logic [IW:0]                feature_count;
  logic [IW:0]                touch_count;
  logic [IW:0]                ptr;
  logic [gbas_pkg::CIDX_W-1:0] ix;
  logic [gbas_pkg::CIDX_W-1:0] iy;
  logic [IW-1:0]              p;
  logic                       pend_valid;
  logic [IW-1:0]              pend_idx;
  logic [CAW-1:0]             init_ctr;

  logic           cell_we, cell_re;
  logic [CAW-1:0] cell_waddr, cell_raddr;
  logic [CW-1:0]  cell_wdata, cell_rdata;
  logic           fs_we, fs_re;
  logic [IW-1:0]  fs_waddr, fs_raddr;
  logic [FW-1:0]  fs_wdata, fs_rdata;
  logic           nx_we, nx_re;
  logic [IW-1:0]  nx_waddr, nx_raddr;
  logic [IW:0]    nx_wdata, nx_rdata;
  logic           tch_we, tch_re;
  logic [IW-1:0]  tch_waddr, tch_raddr;
  logic [CAW-1:0] tch_wdata, tch_rdata;

  logic                        out_free;
  logic                        out_load;
  logic [IW-1:0]               out_idx;
  logic                        out_found;
  logic                        out_last;
  logic [CAW-1:0]              cur_cell;
  logic [CAW-1:0]              walk_cell;
  logic                        cell_last;
  logic                        table_full;
  logic                        head_empty;
  logic                        next_end;
  logic                        match;
  logic                        blocked;
  logic [gbas_pkg::COORD_W-1:0] f_x, f_y, dx, dy;
  logic [gbas_pkg::LEVEL_W-1:0] f_lvl;
  logic signed [gbas_pkg::SLEVEL_W-1:0] f_slvl;

  gbas_ram #(.WIDTH(CW), .DEPTH(NCELLS)) u_cell (
    .clk, .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
    .re(cell_re), .raddr(cell_raddr), .rdata(cell_rdata)
  );
  gbas_ram #(.WIDTH(FW), .DEPTH(MAX_FEATURES)) u_store (
    .clk, .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .re(fs_re), .raddr(fs_raddr), .rdata(fs_rdata)
  );
  gbas_ram #(.WIDTH(IW + 1), .DEPTH(MAX_FEATURES)) u_next (
    .clk, .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .re(nx_re), .raddr(nx_raddr), .rdata(nx_rdata)
  );
  gbas_ram #(.WIDTH(CAW), .DEPTH(MAX_FEATURES)) u_touch (
    .clk, .we(tch_we), .waddr(tch_waddr), .wdata(tch_wdata),
    .re(tch_re), .raddr(tch_raddr), .rdata(tch_rdata)
  );

  // Cell addresses and walk status
  always_comb begin
    cur_cell   = CAW'(CAW'(cur.row0) * CAW'(GRID_COLS) + CAW'(cur.col0));
    walk_cell  = CAW'(CAW'(iy) * CAW'(GRID_COLS) + CAW'(ix));
    cell_last  = (ix == cur.col1) && (iy == cur.row1);
    table_full = (feature_count == (IW + 1)'(MAX_FEATURES));
    head_empty = cell_rdata[CW-1];
    next_end   = nx_rdata[IW];
    out_free   = !res.valid || res.ready;
  end

  // Match test on the fetched feature
  always_comb begin
    {f_x, f_y, f_lvl} = fs_rdata;
    f_slvl  = $signed({1'b0, f_lvl});
    dx      = (f_x > cur.pos_x) ? f_x - cur.pos_x : cur.pos_x - f_x;
    dy      = (f_y > cur.pos_y) ? f_y - cur.pos_y : cur.pos_y - f_y;
    match   = !(f_slvl < cur.min_level)
              && !(cur.max_level >= 0 && f_slvl > cur.max_level)
              && (dx < cur.radius) && (dy < cur.radius);
    blocked = match && pend_valid && !out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gbas_pkg::B_INIT: begin
        if (init_ctr == CAW'(NCELLS - 1)) state_next = gbas_pkg::B_IDLE;
      end
      gbas_pkg::B_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            gbas_pkg::OP_CLEAR:
              state_next = (touch_count == '0) ? gbas_pkg::B_IDLE : gbas_pkg::B_CLR_RD;
            gbas_pkg::OP_INSERT: state_next = gbas_pkg::B_INS_WR;
            gbas_pkg::OP_QUERY:
              state_next = q_cmd.hit ? gbas_pkg::B_Q_CELL : gbas_pkg::B_Q_END;
            default: state_next = gbas_pkg::B_IDLE;
          endcase
        end
      end
      gbas_pkg::B_CLR_RD: state_next = gbas_pkg::B_CLR_WR;
      gbas_pkg::B_CLR_WR: begin
        state_next = (ptr + 1'b1 == touch_count) ? gbas_pkg::B_IDLE : gbas_pkg::B_CLR_RD;
      end
      gbas_pkg::B_INS_WR: begin
        state_next = (table_full || !cur.hit) ? gbas_pkg::B_IDLE : gbas_pkg::B_INS_LINK;
      end
      gbas_pkg::B_INS_LINK: state_next = gbas_pkg::B_IDLE;
      gbas_pkg::B_Q_CELL:   state_next = gbas_pkg::B_Q_HEAD;
      gbas_pkg::B_Q_HEAD: begin
        if (!head_empty)     state_next = gbas_pkg::B_Q_FEAT;
        else if (cell_last)  state_next = gbas_pkg::B_Q_END;
        else                 state_next = gbas_pkg::B_Q_CELL;
      end
      gbas_pkg::B_Q_FEAT: begin
        if (!blocked && next_end) begin
          state_next = cell_last ? gbas_pkg::B_Q_END : gbas_pkg::B_Q_CELL;
        end
      end
      gbas_pkg::B_Q_END: begin
        if (out_free) state_next = gbas_pkg::B_IDLE;
      end
      default: state_next = gbas_pkg::B_IDLE;
    endcase
  end

  // Memory controls, queue pop and result load
  always_comb begin
    q_pop      = 1'b0;
    cell_we    = 1'b0;
    cell_waddr = cur_cell;
    cell_wdata = {1'b1, {(2 * IW){1'b0}}};
    cell_re    = 1'b0;
    cell_raddr = walk_cell;
    fs_we      = 1'b0;
    fs_waddr   = feature_count[IW-1:0];
    fs_wdata   = {cur.pos_x, cur.pos_y, cur.level};
    fs_re      = 1'b0;
    fs_raddr   = cell_rdata[2*IW-1:IW];
    nx_we      = 1'b0;
    nx_waddr   = feature_count[IW-1:0];
    nx_wdata   = {1'b1, {IW{1'b0}}};
    nx_re      = 1'b0;
    nx_raddr   = cell_rdata[2*IW-1:IW];
    tch_we     = 1'b0;
    tch_waddr  = touch_count[IW-1:0];
    tch_wdata  = cur_cell;
    tch_re     = 1'b0;
    tch_raddr  = ptr[IW-1:0];
    out_load   = 1'b0;
    out_idx    = pend_idx;
    out_found  = 1'b1;
    out_last   = 1'b0;
    unique case (state)
      gbas_pkg::B_INIT: begin
        cell_we    = 1'b1;
        cell_waddr = init_ctr;
      end
      gbas_pkg::B_IDLE: q_pop = q_valid;
      gbas_pkg::B_CLR_RD: tch_re = 1'b1;
      gbas_pkg::B_CLR_WR: begin
        cell_we    = 1'b1;
        cell_waddr = tch_rdata;
      end
      gbas_pkg::B_INS_WR: begin
        if (!table_full) begin
          fs_we      = 1'b1;
          nx_we      = 1'b1;
          cell_re    = cur.hit;
          cell_raddr = cur_cell;
        end
      end
      gbas_pkg::B_INS_LINK: begin
        cell_we = 1'b1;
        if (head_empty) begin
          cell_wdata = {1'b0, p, p};
          tch_we     = 1'b1;
        end else begin
          cell_wdata = {1'b0, cell_rdata[2*IW-1:IW], p};
          nx_we      = 1'b1;
          nx_waddr   = cell_rdata[IW-1:0];
          nx_wdata   = {1'b0, p};
        end
      end
      gbas_pkg::B_Q_CELL: cell_re = 1'b1;
      gbas_pkg::B_Q_HEAD: begin
        fs_re = !head_empty;
        nx_re = !head_empty;
      end
      gbas_pkg::B_Q_FEAT: begin
        if (!blocked) begin
          out_load = match && pend_valid;
          fs_re    = !next_end;
          nx_re    = !next_end;
          fs_raddr = nx_rdata[IW-1:0];
          nx_raddr = nx_rdata[IW-1:0];
        end
      end
      gbas_pkg::B_Q_END: begin
        out_load  = out_free;
        out_idx   = pend_valid ? pend_idx : '0;
        out_found = pend_valid;
        out_last  = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gbas_pkg::B_INIT;
      init_ctr      <= '0;
      feature_count <= '0;
      touch_count   <= '0;
      res.valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == gbas_pkg::B_INIT) init_ctr <= init_ctr + 1'b1;
      if (state == gbas_pkg::B_IDLE && q_valid && q_cmd.op == gbas_pkg::OP_CLEAR) begin
        feature_count <= '0;
      end
      if (fs_we) feature_count <= feature_count + 1'b1;
      if (tch_we) touch_count <= touch_count + 1'b1;
      if (state == gbas_pkg::B_CLR_WR && state_next == gbas_pkg::B_IDLE) touch_count <= '0;
      if (out_load)      res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
    end
  end

  // Walk and pending-match registers
  always_ff @(posedge clk) begin
    case (state)
      gbas_pkg::B_IDLE: begin
        cur        <= q_cmd;
        ix         <= q_cmd.col0;
        iy         <= q_cmd.row0;
        ptr        <= '0;
        pend_valid <= 1'b0;
      end
      gbas_pkg::B_CLR_WR: ptr <= ptr + 1'b1;
      gbas_pkg::B_INS_WR: p <= feature_count[IW-1:0];
      gbas_pkg::B_Q_HEAD: begin
        if (!head_empty) begin
          p <= cell_rdata[2*IW-1:IW];
        end else if (!cell_last) begin
          if (iy == cur.row1) begin
            iy <= cur.row0;
            ix <= ix + 1'b1;
          end else begin
            iy <= iy + 1'b1;
          end
        end
      end
      gbas_pkg::B_Q_FEAT: begin
        if (!blocked) begin
          if (match) begin
            pend_idx   <= p;
            pend_valid <= 1'b1;
          end
          if (!next_end) begin
            p <= nx_rdata[IW-1:0];
          end else if (!cell_last) begin
            if (iy == cur.row1) begin
              iy <= cur.row0;
              ix <= ix + 1'b1;
            end else begin
              iy <= iy + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      res.feature_index <= gbas_pkg::IDX_OUT_W'(out_idx);
      res.found         <= out_found;
      res.last          <= out_last;
    end
  end
endmodule
